[rtl/core/ptpe_pkg.sv]
// ----------------------------------------------------------------------------
// ptpe_pkg - shared types and helpers for the path turn-point extractor
// Item structs, step and angle types, and the eight-direction angle lookup.
// ----------------------------------------------------------------------------
package ptpe_pkg;

	localparam int COORD_W = 12;
	localparam int STEP_W  = COORD_W + 1;
	localparam int TURN_W  = 9;
	localparam int COUNT_W = 16;
	localparam int SEEN_W  = 2;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [SEEN_W-1:0]  SEEN_NONE  = 2'd0;
	localparam logic [SEEN_W-1:0]  SEEN_ONE   = 2'd1;
	localparam logic [SEEN_W-1:0]  SEEN_TWO   = 2'd2;

	localparam logic [TURN_W-1:0] ANG_NONE = 9'd0;
	localparam logic [TURN_W-1:0] ANG_NE   = 9'd45;
	localparam logic [TURN_W-1:0] ANG_E    = 9'd90;
	localparam logic [TURN_W-1:0] ANG_SE   = 9'd135;
	localparam logic [TURN_W-1:0] ANG_S    = 9'd180;
	localparam logic [TURN_W-1:0] ANG_SW   = 9'd225;
	localparam logic [TURN_W-1:0] ANG_W    = 9'd270;
	localparam logic [TURN_W-1:0] ANG_NW   = 9'd315;
	localparam logic [TURN_W-1:0] ANG_FULL = 9'd360;

	typedef logic [COORD_W-1:0]       coord_t;
	typedef logic signed [STEP_W-1:0] step_t;
	typedef logic [TURN_W-1:0]        angle_t;
	typedef logic [COUNT_W-1:0]       count_t;

	typedef struct packed {
		logic   start_of_path;
		coord_t point_x;
		coord_t point_y;
	} in_item_t;

	typedef struct packed {
		coord_t way_x;
		coord_t way_y;
		angle_t turn_degrees;
		count_t waypoint_number;
	} out_item_t;

	// Step comparison result handed from the turn unit to the top level
	typedef struct packed {
		logic   differ;
		angle_t turn;
	} turn_info_t;

	// Signed difference of two grid coordinates
	function automatic step_t step_of(input coord_t to_c, input coord_t from_c);
		step_of = step_t'({1'b0, to_c}) - step_t'({1'b0, from_c});
	endfunction

	// Angle of a unit step; any other step maps to zero
	function automatic angle_t angle_of(input step_t dx, input step_t dy);
		angle_t a;
		a = ANG_NONE;
		if (dx == 13'sd1) begin
			if (dy == 13'sd1)       a = ANG_NW;
			else if (dy == 13'sd0)  a = ANG_W;
			else if (dy == -13'sd1) a = ANG_SW;
		end else if (dx == 13'sd0) begin
			if (dy == 13'sd1)       a = ANG_FULL;
			else if (dy == -13'sd1) a = ANG_S;
		end else if (dx == -13'sd1) begin
			if (dy == 13'sd1)       a = ANG_NE;
			else if (dy == 13'sd0)  a = ANG_E;
			else if (dy == -13'sd1) a = ANG_SE;
		end
		angle_of = a;
	endfunction

endpackage

[rtl/core/ptpe_turn.sv]
// ----------------------------------------------------------------------------
// ptpe_turn - step comparison and turn angle
// Compares the incoming step with the stored one and forms the wrapped turn.
// ----------------------------------------------------------------------------
module ptpe_turn (
	input  ptpe_pkg::coord_t     older_x,
	input  ptpe_pkg::coord_t     older_y,
	input  ptpe_pkg::coord_t     newer_x,
	input  ptpe_pkg::coord_t     newer_y,
	input  ptpe_pkg::coord_t     point_x,
	input  ptpe_pkg::coord_t     point_y,
	output ptpe_pkg::turn_info_t info
);
	import ptpe_pkg::*;

	step_t               ndx, ndy, odx, ody;
	angle_t              ang_old, ang_new;
	logic signed [TURN_W:0] diff;

	// Form both steps and their angles
	assign ndx     = step_of(point_x, newer_x);
	assign ndy     = step_of(point_y, newer_y);
	assign odx     = step_of(newer_x, older_x);
	assign ody     = step_of(newer_y, older_y);
	assign ang_old = angle_of(odx, ody);
	assign ang_new = angle_of(ndx, ndy);

	// Subtract the new angle and wrap into 0..360
	assign diff = $signed({1'b0, ang_old}) - $signed({1'b0, ang_new});

	always_comb begin
		info.differ = (ndx != odx) || (ndy != ody);
		if (diff < 0) begin
			info.turn = angle_t'(diff + $signed({1'b0, ANG_FULL}));
		end else begin
			info.turn = angle_t'(diff);
		end
	end

endmodule

[rtl/core/path_turn_point_extractor.sv]
// ----------------------------------------------------------------------------
// path_turn_point_extractor - waypoint extraction from grid paths
// Emits path start points and points where the step changes.
// ----------------------------------------------------------------------------
// One path point is taken per cycle while in_ready is high. Each point is
// checked against the two stored points in a single combinational pass and
// its waypoint, if any, lands in the output register at the next edge. The
// output register lets a new point in while the waypoint is being taken;
// in_ready drops only while a waypoint waits and out_ready is low. A point
// with start_of_path set, or the first point after reset, opens a path and is
// emitted with turn 0 and number 0.
// ----------------------------------------------------------------------------
module path_turn_point_extractor (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ptpe_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output ptpe_pkg::out_item_t out_item
);
	import ptpe_pkg::*;

	coord_t              older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [SEEN_W-1:0]   seen_q;
	count_t              count_q;
	logic                out_valid_q;
	out_item_t           out_item_q;

	turn_info_t          info;
	logic                accept;
	logic                open_path;
	logic                emit;

	ptpe_turn u_turn (
		.older_x (older_x_q),
		.older_y (older_y_q),
		.newer_x (newer_x_q),
		.newer_y (newer_y_q),
		.point_x (in_item.point_x),
		.point_y (in_item.point_y),
		.info    (info)
	);

	// Handshake and emit decision
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign open_path = in_item.start_of_path || (seen_q == SEEN_NONE);
	assign emit      = open_path || ((seen_q == SEEN_TWO) && info.differ);

	// Advance point history and waypoint count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			older_x_q <= '0;
			older_y_q <= '0;
			newer_x_q <= '0;
			newer_y_q <= '0;
			seen_q    <= SEEN_NONE;
			count_q   <= '0;
		end else if (accept) begin
			newer_x_q <= in_item.point_x;
			newer_y_q <= in_item.point_y;
			if (open_path) begin
				older_x_q <= '0;
				older_y_q <= '0;
				seen_q    <= SEEN_ONE;
				count_q   <= count_t'(1);
			end else begin
				older_x_q <= newer_x_q;
				older_y_q <= newer_y_q;
				seen_q    <= SEEN_TWO;
				if (emit && (count_q != COUNT_MAX)) begin
					count_q <= count_q + count_t'(1);
				end
			end
		end
	end

	// Hold result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			out_item_q.way_x <= in_item.point_x;
			out_item_q.way_y <= in_item.point_y;
			if (open_path) begin
				out_item_q.turn_degrees    <= ANG_NONE;
				out_item_q.waypoint_number <= '0;
			end else begin
				out_item_q.turn_degrees    <= info.turn;
				out_item_q.waypoint_number <= count_q;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule
